### sv/kil_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kil_pkg
// Shared types, character codes and the keyword match for the lexer.
// ----------------------------------------------------------------------------
package kil_pkg;

	typedef enum logic [1:0] {
		KIND_KEYWORD = 2'd0,
		KIND_IDENT   = 2'd1,
		KIND_SYMBOL  = 2'd2,
		KIND_END     = 2'd3
	} token_kind_t;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;

	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam logic [7:0]  LEN_MAX = 8'hFF;

	typedef struct packed {
		token_kind_t kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [7:0]  length;
		logic [7:0]  symbol;
		logic        last;
	} token_t;

	// Tokens raised by one transaction: count is 0, 1 or 2, tok0 goes first
	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

	// Prefix byte 0 is the first character; unused bytes are zero
	function automatic logic is_keyword(input logic [3:0][7:0] p, input logic [7:0] n);
		logic hit;
		hit = 1'b0;
		if (n == 8'd4 && p == {"d", "i", "o", "v"}) hit = 1'b1;
		if (n == 8'd4 && p == {"n", "i", "a", "m"}) hit = 1'b1;
		if (n == 8'd3 && p == {8'h00, "t", "n", "i"}) hit = 1'b1;
		if (n == 8'd2 && p == {8'h00, 8'h00, "f", "i"}) hit = 1'b1;
		if (n == 8'd4 && p == {"e", "s", "l", "e"}) hit = 1'b1;
		return hit;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == POS_MAX) ? v : v + 16'd1;
	endfunction

endpackage
`default_nettype wire

### sv/keyword_identifier_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_identifier_lexer
// Character-at-a-time lexer for keywords, identifiers and special symbols.
// ----------------------------------------------------------------------------
// One character (or end marker) per transaction is registered in the input
// stage, classified and turned into zero, one or two tokens, which are written
// into a four-entry queue; tokens leave the queue from its head one per cycle
// while out_stall is low. Input is taken every cycle while the queue has room
// for the tokens of the registered character, so the sustained rate is one
// character per cycle, limited by the single-token output port when more than
// one token per character is produced on average.
module keyword_identifier_lexer import kil_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        end_of_input,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       token_kind,
	output logic [15:0]      line,
	output logic [15:0]      column,
	output logic [7:0]       length,
	output logic [7:0]       symbol,
	output logic             last_of_run
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eoi_s1;
	logic       fire, pop;
	logic [2:0] free;
	push_t      core_push, push;
	token_t     head;

	kil_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ch           (ch_s1),
		.end_of_input (eoi_s1),
		.fire         (fire),
		.push         (core_push)
	);

	assign fire     = valid_s1 && (free >= {1'b0, core_push.count});
	assign in_stall = valid_s1 && !fire;

	always_comb begin
		push       = core_push;
		push.count = fire ? core_push.count : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1  <= ch;
			eoi_s1 <= end_of_input;
		end
	end

	kil_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.free      (free)
	);

	assign pop         = out_valid && !out_stall;
	assign token_kind  = head.kind;
	assign line        = head.line;
	assign column      = head.column;
	assign length      = head.length;
	assign symbol      = head.symbol;
	assign last_of_run = head.last;

`ifndef SYNTHESIS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_END |-> last_of_run && length == 8'd0)
		else $error("end token not last of run or has non-zero length");
	a_symbol_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_SYMBOL |-> length == 8'd1 && symbol != 8'h00)
		else $error("symbol token malformed");
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line != 16'd0 && column != 16'd0)
		else $error("token position is zero");
	a_keyword_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_KEYWORD |-> length >= 8'd2 && length <= 8'd4)
		else $error("keyword length out of range");
`endif

endmodule
`default_nettype wire

### sv/kil_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kil_core
// Character classification, position and word state, token generation.
// ----------------------------------------------------------------------------
module kil_core import kil_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  ch,
	input  wire logic        end_of_input,
	input  wire logic        fire,
	output push_t            push
);

	logic             in_word_q;
	logic [15:0]      line_q;
	logic [15:0]      col_q;
	logic [15:0]      start_col_q;
	logic [7:0]       len_q;
	logic [3:0][7:0]  prefix_q;

	logic   letter, digit, sym, flush, second_en;
	token_t word_tok, sec_tok;

	always_comb begin
		letter = (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
		digit  = (ch >= "0" && ch <= "9");
		sym    = (ch == CH_COMMA) || (ch == CH_SEMI) || (ch == CH_LBRACE) ||
		         (ch == CH_RBRACE) || (ch == CH_LPAREN) || (ch == CH_RPAREN);
		flush     = in_word_q && (end_of_input || !(letter || digit));
		second_en = end_of_input || sym;

		word_tok.kind   = is_keyword(prefix_q, len_q) ? KIND_KEYWORD : KIND_IDENT;
		word_tok.line   = line_q;
		word_tok.column = start_col_q;
		word_tok.length = len_q;
		word_tok.symbol = 8'h00;
		word_tok.last   = !second_en;

		sec_tok.kind   = end_of_input ? KIND_END : KIND_SYMBOL;
		sec_tok.line   = line_q;
		sec_tok.column = col_q;
		sec_tok.length = end_of_input ? 8'd0 : 8'd1;
		sec_tok.symbol = end_of_input ? 8'h00 : ch;
		sec_tok.last   = 1'b1;

		push.count = {flush & second_en, flush ^ second_en};
		push.tok0  = flush ? word_tok : sec_tok;
		push.tok1  = sec_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q   <= 1'b0;
			line_q      <= 16'd1;
			col_q       <= 16'd1;
			start_col_q <= 16'd1;
			len_q       <= 8'd0;
			prefix_q    <= '0;
		end else if (fire) begin
			if (end_of_input) begin
				in_word_q   <= 1'b0;
				line_q      <= 16'd1;
				col_q       <= 16'd1;
				start_col_q <= 16'd1;
				len_q       <= 8'd0;
				prefix_q    <= '0;
			end else if (in_word_q && (letter || digit)) begin
				if (len_q < 8'd4)
					prefix_q[len_q[1:0]] <= ch;
				if (len_q != LEN_MAX)
					len_q <= len_q + 8'd1;
				col_q <= sat_inc16(col_q);
			end else begin
				in_word_q <= 1'b0;
				if (letter) begin
					in_word_q   <= 1'b1;
					start_col_q <= col_q;
					len_q       <= 8'd1;
					prefix_q    <= {8'h00, 8'h00, 8'h00, ch};
					col_q       <= sat_inc16(col_q);
				end else if (ch == CH_NEWLINE) begin
					line_q <= sat_inc16(line_q);
					col_q  <= 16'd1;
				end else begin
					col_q <= sat_inc16(col_q);
				end
			end
		end
	end

endmodule
`default_nettype wire

### sv/kil_token_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kil_token_fifo
// Four-entry token queue: takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module kil_token_fifo import kil_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire push_t      push,
	input  wire logic       pop,
	output token_t          head,
	output logic            not_empty,
	output logic [2:0]      free
);

	localparam int DEPTH = 4;

	token_t     mem_q [DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic [1:0] wr_next;

	assign wr_next   = wr_ptr_q + 2'd1;
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != 3'd0);
	assign free      = 3'(DEPTH) - count_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.tok0;
		if (push.count == 2'd2)
			mem_q[wr_next] <= push.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

endmodule
`default_nettype wire
